### rtl/gsbc_pkg.sv
// gyro scale and bias calibration: shared types, constants and the range factor table
`default_nettype none

package gsbc_pkg;

    localparam int AXES        = 3;
    localparam int RAW_W       = 16;
    localparam int FACTOR_W    = 15;
    localparam int PROD_W      = 32;
    localparam int SCALE_SHIFT = 8;
    localparam int SCALED_W    = 23;
    localparam int RATE_W      = 24;
    localparam int SUM_W       = 32;
    localparam int SQ_W        = 2 * RATE_W - 1;
    localparam int MAG_W       = SQ_W + 2;
    localparam int LIM_W       = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int RANGE_W     = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_LIMIT = 2'd2;

    // range codes
    localparam logic [RANGE_W-1:0] RANGE_DPS2000  = 3'd0;
    localparam logic [RANGE_W-1:0] RANGE_DPS1000  = 3'd1;
    localparam logic [RANGE_W-1:0] RANGE_DPS500   = 3'd2;
    localparam logic [RANGE_W-1:0] RANGE_DPS250   = 3'd3;
    localparam logic [RANGE_W-1:0] RANGE_DPS125   = 3'd4;
    localparam logic [RANGE_W-1:0] RANGE_CODE_MAX = RANGE_DPS125;

    // opcodes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [RANGE_W-1:0] RANGE_RESET       = RANGE_DPS1000;
    localparam logic [CFG_W-1:0]   CAL_SAMPLES_RESET = 16'd1000;
    localparam logic [CFG_W-1:0]   STILL_LIMIT_RESET = 16'd13107;

    localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;
    localparam logic signed [RATE_W-1:0] RATE_MIN = 24'sh800000;
    localparam logic signed [SUM_W-1:0]  SUM_MAX  = 32'sh7FFFFFFF;
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = 32'sh80000000;

    typedef struct packed {
        logic                              opcode;
        logic [AXES-1:0][SCALED_W-1:0]     scaled;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_SQUARE,
        S_CHECK,
        S_DIV
    } t_back_state;

    // counts to Q6.16 rad/s, times 256
    function automatic logic [FACTOR_W-1:0] range_factor(input logic [RANGE_W-1:0] code);
        logic [FACTOR_W-1:0] f;
        case (code)
            RANGE_DPS2000: f = 15'd17872;
            RANGE_DPS1000: f = 15'd8936;
            RANGE_DPS500:  f = 15'd4468;
            RANGE_DPS250:  f = 15'd2234;
            RANGE_DPS125:  f = 15'd1117;
            default:       f = 15'd8936;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

### rtl/gsbc_front.sv
// front stage: takes input items and scales the raw readings to Q6.16
`default_nettype none

module gsbc_front import gsbc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_opcode,
    input  logic signed [RAW_W-1:0] i_raw [AXES],
    input  logic [RANGE_W-1:0]      i_gyro_range,
    input  logic                    i_q_full,
    output logic                    o_q_push,
    output t_item                   o_q_item
);

    logic                    r_vld;
    logic                    r_opcode;
    logic signed [RAW_W-1:0] r_raw [AXES];
    logic [FACTOR_W-1:0]     r_factor;
    logic signed [PROD_W-1:0] w_prod [AXES];
    logic                    w_accept;

    assign full     = r_vld && i_q_full;
    assign w_accept = push && !full;
    assign o_q_push = r_vld && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (o_q_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_opcode <= i_opcode;
            r_raw    <= i_raw;
            r_factor <= range_factor(i_gyro_range);
        end
    end

    // taking the upper bits of the product is a floor shift
    always_comb begin
        o_q_item.opcode = r_opcode;
        for (int i = 0; i < AXES; i++) begin
            w_prod[i] = PROD_W'(r_raw[i]) * PROD_W'($signed({1'b0, r_factor}));
            o_q_item.scaled[i] = w_prod[i][SCALED_W+SCALE_SHIFT-1:SCALE_SHIFT];
        end
    end

endmodule

`default_nettype wire

### rtl/gsbc_queue.sv
// short item queue between the front and back stages
`default_nettype none

module gsbc_queue import gsbc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_item              i_item,
    input  logic               i_pop,
    output t_item              o_item,
    output logic               o_full,
    output logic               o_empty,
    output logic [Q_CNT_W-1:0] o_count
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full  = r_cnt == Q_CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_count = r_cnt;
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + Q_PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

### rtl/gsbc_div.sv
// three-lane restoring divider for the bias means, one quotient bit per cycle
`default_nettype none

module gsbc_div import gsbc_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SUM_W-1:0]  i_dvd [AXES],
    input  logic [COUNT_WIDTH-1:0]   i_divisor,
    output logic                     o_busy,
    output logic                     o_done,
    output logic signed [RATE_W-1:0] o_quot [AXES]
);

    localparam int STEP_W = $clog2(SUM_W);

    logic                   r_busy;
    logic                   r_done;
    logic [STEP_W-1:0]      r_cnt;
    logic [COUNT_WIDTH-1:0] r_divisor;
    logic [SUM_W-1:0]       r_dvd [AXES];
    logic [COUNT_WIDTH-1:0] r_rem [AXES];
    logic                   r_neg [AXES];

    logic [COUNT_WIDTH:0]   w_trial [AXES];
    logic [COUNT_WIDTH:0]   w_diff  [AXES];
    logic                   w_bit   [AXES];
    logic [COUNT_WIDTH-1:0] w_rem   [AXES];
    logic [SUM_W-1:0]       w_mag   [AXES];

    assign o_busy = r_busy;
    assign o_done = r_done;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_mag[i]   = i_dvd[i][SUM_W-1] ? SUM_W'(-i_dvd[i]) : SUM_W'(i_dvd[i]);
            w_trial[i] = {r_rem[i], r_dvd[i][SUM_W-1]};
            w_diff[i]  = w_trial[i] - {1'b0, r_divisor};
            w_bit[i]   = w_trial[i] >= {1'b0, r_divisor};
            w_rem[i]   = w_bit[i] ? w_diff[i][COUNT_WIDTH-1:0]
                                  : w_trial[i][COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            for (int i = 0; i < AXES; i++) begin
                r_dvd[i] <= w_mag[i];
                r_rem[i] <= '0;
                r_neg[i] <= i_dvd[i][SUM_W-1];
            end
        end else if (r_busy) begin
            for (int i = 0; i < AXES; i++) begin
                r_dvd[i] <= {r_dvd[i][SUM_W-2:0], w_bit[i]};
                r_rem[i] <= w_rem[i];
            end
        end
    end

    // sign the quotient magnitude and clamp it to the rate range
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            if (r_neg[i]) begin
                if ((|r_dvd[i][SUM_W-1:RATE_W])
                    || (r_dvd[i][RATE_W-1] && (|r_dvd[i][RATE_W-2:0]))) begin
                    o_quot[i] = RATE_MIN;
                end else begin
                    o_quot[i] = -$signed(r_dvd[i][RATE_W-1:0]);
                end
            end else begin
                if (|r_dvd[i][SUM_W-1:RATE_W-1]) begin
                    o_quot[i] = RATE_MAX;
                end else begin
                    o_quot[i] = $signed(r_dvd[i][RATE_W-1:0]);
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/gsbc_back.sv
// back stage: offset correction, stillness test, accumulation and result register
`default_nettype none

module gsbc_back import gsbc_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_empty,
    input  t_item                    i_q_item,
    output logic                     o_q_pop,
    input  logic [CFG_W-1:0]         i_cal_samples,
    input  logic [CFG_W-1:0]         i_still_limit,
    output logic                     o_div_start,
    output logic signed [SUM_W-1:0]  o_div_sum [AXES],
    output logic [COUNT_WIDTH-1:0]   o_div_count,
    input  logic                     i_div_done,
    input  logic signed [RATE_W-1:0] i_div_quot [AXES],
    input  logic                     i_pop,
    output logic                     o_out_vld,
    output logic signed [RATE_W-1:0] o_rate [AXES],
    output logic                     o_calibrated
);

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    t_back_state              r_state;
    t_back_state              n_state;
    logic [COUNT_WIDTH-1:0]   r_count;
    logic signed [SUM_W-1:0]  r_sum [AXES];
    logic signed [RATE_W-1:0] r_off [AXES];
    logic [SCALED_W-1:0]      r_scaled [AXES];
    logic signed [RATE_W-1:0] r_rate [AXES];
    logic [SQ_W-1:0]          r_sq [AXES];
    logic [LIM_W-1:0]         r_lim;
    logic                     r_out_vld;
    logic signed [RATE_W-1:0] r_out_rate [AXES];
    logic                     r_out_cal;

    logic signed [2*RATE_W-1:0] w_sq [AXES];
    logic [LIM_W-1:0]           w_lim;
    logic [MAG_W-1:0]           w_mag;
    logic                       w_gather;
    logic                       w_still;
    logic                       w_count_zero;
    logic                       w_count_max;

    function automatic logic signed [RATE_W-1:0] sat_rate(
        input logic signed [SCALED_W-1:0] s,
        input logic signed [RATE_W-1:0]   off
    );
        logic signed [RATE_W:0] d;
        d = (RATE_W+1)'(s) - (RATE_W+1)'(off);
        if (d[RATE_W] != d[RATE_W-1]) begin
            return d[RATE_W] ? RATE_MIN : RATE_MAX;
        end
        return d[RATE_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(
        input logic signed [SUM_W-1:0]  s,
        input logic signed [RATE_W-1:0] r
    );
        logic signed [SUM_W:0] a;
        a = (SUM_W+1)'(s) + (SUM_W+1)'(r);
        if (a[SUM_W] != a[SUM_W-1]) begin
            return a[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return a[SUM_W-1:0];
    endfunction

    assign w_lim        = LIM_W'(i_still_limit) * LIM_W'(i_still_limit);
    assign w_gather     = CMP_W'(r_count) < CMP_W'(i_cal_samples);
    assign w_count_zero = r_count == '0;
    assign w_count_max  = &r_count;
    assign w_still      = w_mag < MAG_W'(r_lim);

    always_comb begin
        w_mag = '0;
        for (int i = 0; i < AXES; i++) begin
            w_sq[i] = (2*RATE_W)'(r_rate[i]) * (2*RATE_W)'(r_rate[i]);
            w_mag   = w_mag + MAG_W'(r_sq[i]);
        end
    end

    assign o_div_sum    = r_sum;
    assign o_div_count  = r_count;
    assign o_out_vld    = r_out_vld;
    assign o_rate       = r_out_rate;
    assign o_calibrated = r_out_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        o_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && !r_out_vld) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.opcode != OP_RESTART) begin
                        n_state = S_RATE;
                    end
                end
            end
            S_RATE:   n_state = S_SQUARE;
            S_SQUARE: n_state = S_CHECK;
            S_CHECK: begin
                if (w_gather || w_count_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (i_div_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_count   <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_sum[i] <= '0;
                r_off[i] <= '0;
            end
        end else begin
            if (i_pop && r_out_vld) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_item.opcode == OP_RESTART) begin
                            r_count   <= '0;
                            r_out_cal <= 1'b0;
                            r_out_vld <= 1'b1;
                            for (int i = 0; i < AXES; i++) begin
                                r_sum[i]      <= '0;
                                r_off[i]      <= '0;
                                r_out_rate[i] <= '0;
                            end
                        end else begin
                            for (int i = 0; i < AXES; i++) begin
                                r_scaled[i] <= i_q_item.scaled[i];
                            end
                        end
                    end
                end
                S_RATE: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_rate[i] <= sat_rate($signed(r_scaled[i]), r_off[i]);
                    end
                end
                S_SQUARE: begin
                    r_lim <= w_lim;
                    for (int i = 0; i < AXES; i++) begin
                        r_sq[i] <= w_sq[i][SQ_W-1:0];
                    end
                end
                S_CHECK: begin
                    if (w_gather) begin
                        if (w_still && !w_count_max) begin
                            r_count <= r_count + COUNT_WIDTH'(1);
                            for (int i = 0; i < AXES; i++) begin
                                r_sum[i] <= sat_sum(r_sum[i], r_rate[i]);
                            end
                        end
                        r_out_rate <= r_rate;
                        r_out_cal  <= 1'b0;
                        r_out_vld  <= 1'b1;
                    end else if (w_count_zero) begin
                        // target met with nothing gathered
                        for (int i = 0; i < AXES; i++) begin
                            r_off[i] <= '0;
                        end
                        r_out_rate <= r_rate;
                        r_out_cal  <= 1'b1;
                        r_out_vld  <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (i_div_done) begin
                        r_off      <= i_div_quot;
                        r_out_rate <= r_rate;
                        r_out_cal  <= 1'b1;
                        r_out_vld  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/gyro_scale_and_bias_calibration.sv
// a restart result is set on its pop, a sample result after the rate, square, check states
// once the still target is met, a sample with a nonzero count runs the 32-step bias divider
// the back stage sequencer takes a sample only once the last is done and its result popped
// the front stage and a 2-entry queue take new items while a result waits
// reset is synchronous, active low: settings return to defaults, calibration is cleared
`default_nettype none

module gyro_scale_and_bias_calibration import gsbc_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     i_opcode,
    input  logic signed [RAW_W-1:0]  i_raw_x,
    input  logic signed [RAW_W-1:0]  i_raw_y,
    input  logic signed [RAW_W-1:0]  i_raw_z,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [RATE_W-1:0] o_rate_x,
    output logic signed [RATE_W-1:0] o_rate_y,
    output logic signed [RATE_W-1:0] o_rate_z,
    output logic                     o_calibrated,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    logic [RANGE_W-1:0] r_gyro_range;
    logic [CFG_W-1:0]   r_cal_samples;
    logic [CFG_W-1:0]   r_still_limit;

    logic signed [RAW_W-1:0]  w_raw [AXES];
    logic                     w_q_push;
    t_item                    w_q_in;
    logic                     w_q_pop;
    t_item                    w_q_out;
    logic                     w_q_full;
    logic                     w_q_empty;
    logic [Q_CNT_W-1:0]       w_q_cnt;
    logic                     w_div_start;
    logic signed [SUM_W-1:0]  w_div_sum [AXES];
    logic [COUNT_WIDTH-1:0]   w_div_count;
    logic                     w_div_busy;
    logic                     w_div_done;
    logic signed [RATE_W-1:0] w_div_quot [AXES];
    logic                     w_out_vld;
    logic signed [RATE_W-1:0] w_rate [AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_range  <= RANGE_RESET;
            r_cal_samples <= CAL_SAMPLES_RESET;
            r_still_limit <= STILL_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GYRO_RANGE: begin
                    // codes without meaning leave the range as it was
                    if (i_cfg_data[RANGE_W-1:0] <= RANGE_CODE_MAX) begin
                        r_gyro_range <= i_cfg_data[RANGE_W-1:0];
                    end
                end
                CFG_CAL_SAMPLES: r_cal_samples <= i_cfg_data;
                CFG_STILL_LIMIT: r_still_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_raw = '{i_raw_x, i_raw_y, i_raw_z};

    gsbc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_raw        (w_raw),
        .i_gyro_range (r_gyro_range),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_item     (w_q_in)
    );

    gsbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .i_pop   (w_q_pop),
        .o_item  (w_q_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_count (w_q_cnt)
    );

    gsbc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_item      (w_q_out),
        .o_q_pop       (w_q_pop),
        .i_cal_samples (r_cal_samples),
        .i_still_limit (r_still_limit),
        .o_div_start   (w_div_start),
        .o_div_sum     (w_div_sum),
        .o_div_count   (w_div_count),
        .i_div_done    (w_div_done),
        .i_div_quot    (w_div_quot),
        .i_pop         (pop),
        .o_out_vld     (w_out_vld),
        .o_rate        (w_rate),
        .o_calibrated  (o_calibrated)
    );

    gsbc_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dvd     (w_div_sum),
        .i_divisor (w_div_count),
        .o_busy    (w_div_busy),
        .o_done    (w_div_done),
        .o_quot    (w_div_quot)
    );

    assign empty    = !w_out_vld;
    assign o_rate_x = w_rate[0];
    assign o_rate_y = w_rate[1];
    assign o_rate_z = w_rate[2];

`ifndef SYNTH
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("item pushed into a full queue");

    a_queue_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_cnt <= Q_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    a_div_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> $past(w_div_busy))
        else $error("divider done without a division in flight");
`endif

endmodule

`default_nettype wire

### bench/gyro_scale_and_bias_calibration_tb.sv
// testbench for gyro_scale_and_bias_calibration: random and directed samples checked against a rate predictor
`timescale 1ns / 100ps

module gyro_scale_and_bias_calibration_tb;
    import gsbc_pkg::*;

    localparam int COUNT_WIDTH   = 16;
    localparam int COUNT_MAX     = 2 ** COUNT_WIDTH - 1;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int TAIL_CYCLES   = 64;
    // a correct run stays well inside the cycle limit, even with every sample on the divider path
    localparam int CYCLE_LIMIT   = 500_000;
    localparam logic [RANGE_W-1:0] RANGE_BAD_LO = 3'd5;
    localparam logic [RANGE_W-1:0] RANGE_BAD_HI = 3'd7;

    typedef struct packed {
        logic [RATE_W-1:0] x;
        logic [RATE_W-1:0] y;
        logic [RATE_W-1:0] z;
        logic              calibrated;
    } rate_set_t;

    class calib_scoreboard;
        logic [RANGE_W-1:0] range_code;
        logic [CFG_W-1:0]   target;
        logic [CFG_W-1:0]   limit;
        longint             still_count;
        longint             sum_acc [AXES];
        longint             offset [AXES];
        rate_set_t          rates_due [$];
        int                 errors;

        function new();
            range_code = RANGE_RESET;
            target     = CAL_SAMPLES_RESET;
            limit      = STILL_LIMIT_RESET;
            errors     = 0;
            clear_calibration();
        endfunction

        function void clear_calibration();
            still_count = 0;
            for (int a = 0; a < AXES; a++) begin
                sum_acc[a] = 0;
                offset[a]  = 0;
            end
        endfunction

        function longint gain();
            case (range_code)
                RANGE_DPS2000: return 17872;
                RANGE_DPS1000: return 8936;
                RANGE_DPS500:  return 4468;
                RANGE_DPS250:  return 2234;
                RANGE_DPS125:  return 1117;
                default:       return 8936;
            endcase
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_GYRO_RANGE: begin
                    // codes past 125 deg/s are dropped
                    if (data[RANGE_W-1:0] <= RANGE_CODE_MAX) range_code = data[RANGE_W-1:0];
                end
                CFG_CAL_SAMPLES: target = data;
                CFG_STILL_LIMIT: limit = data;
                default: ;
            endcase
        endfunction

        function void note_item(logic op, logic signed [RAW_W-1:0] x,
                                logic signed [RAW_W-1:0] y, logic signed [RAW_W-1:0] z);
            longint    raw [AXES];
            longint    rate [AXES];
            longint    mag;
            rate_set_t res;
            raw[0] = x;
            raw[1] = y;
            raw[2] = z;
            res = '0;
            if (op == OP_RESTART) begin
                clear_calibration();
                rates_due.push_back(res);
                return;
            end
            mag = 0;
            for (int a = 0; a < AXES; a++) begin
                rate[a] = clamp(((raw[a] * gain()) >>> SCALE_SHIFT) - offset[a],
                                RATE_MIN, RATE_MAX);
                mag += rate[a] * rate[a];
            end
            if (still_count < target) begin
                if (mag < longint'(limit) * longint'(limit) && still_count < COUNT_MAX) begin
                    still_count++;
                    for (int a = 0; a < AXES; a++)
                        sum_acc[a] = clamp(sum_acc[a] + rate[a], SUM_MIN, SUM_MAX);
                end
            end else begin
                // target met: bias is the truncated mean, zero when nothing was gathered
                for (int a = 0; a < AXES; a++)
                    offset[a] = (still_count == 0) ? 0 :
                                clamp(sum_acc[a] / still_count, RATE_MIN, RATE_MAX);
                res.calibrated = 1'b1;
            end
            res.x = RATE_W'(rate[0]);
            res.y = RATE_W'(rate[1]);
            res.z = RATE_W'(rate[2]);
            rates_due.push_back(res);
        endfunction

        function void compare_field(string name, logic [RATE_W-1:0] want,
                                    logic [RATE_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name,
                         $signed(want), $signed(got));
            end
        endfunction

        function void check_rates(rate_set_t got);
            rate_set_t want;
            if (rates_due.size() == 0) begin
                errors++;
                $display("%0t: result expected none, got rate_x %0d rate_y %0d rate_z %0d",
                         $time, $signed(got.x), $signed(got.y), $signed(got.z));
                return;
            end
            want = rates_due.pop_front();
            compare_field("rate_x", want.x, got.x);
            compare_field("rate_y", want.y, got.y);
            compare_field("rate_z", want.z, got.z);
            compare_field("calibrated", want.calibrated, got.calibrated);
        endfunction

        function int pending();
            return rates_due.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic                     i_opcode = OP_SAMPLE;
    logic signed [RAW_W-1:0]  i_raw_x = '0;
    logic signed [RAW_W-1:0]  i_raw_y = '0;
    logic signed [RAW_W-1:0]  i_raw_z = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic signed [RATE_W-1:0] o_rate_x;
    logic signed [RATE_W-1:0] o_rate_y;
    logic signed [RATE_W-1:0] o_rate_z;
    logic                     o_calibrated;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = CFG_GYRO_RANGE;
    logic [CFG_W-1:0]         i_cfg_data = '0;

    calib_scoreboard sb;
    rate_set_t       seen;
    bit              steady = 1'b0;
    int unsigned     cycle_count = 0;

    assign seen = {o_rate_x, o_rate_y, o_rate_z, o_calibrated};

    gyro_scale_and_bias_calibration #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_raw_x      (i_raw_x),
        .i_raw_y      (i_raw_y),
        .i_raw_z      (i_raw_z),
        .empty        (empty),
        .pop          (pop),
        .o_rate_x     (o_rate_x),
        .o_rate_y     (o_rate_y),
        .o_rate_z     (o_rate_z),
        .o_calibrated (o_calibrated),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        pop <= steady || ($urandom_range(99) >= 22);
        if (i_rst_n && pop && !empty) sb.check_rates(seen);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("gyro_scale_and_bias_calibration regression: fail");
            $finish;
        end
    end

    function automatic int spread(int amp);
        int span;
        span = (amp > 32767) ? 32767 : amp;
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic send_item(logic op, logic signed [RAW_W-1:0] x,
                             logic signed [RAW_W-1:0] y, logic signed [RAW_W-1:0] z);
        i_cfg_we <= 1'b0;
        while (!steady && $urandom_range(99) < 22) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_opcode <= op;
        i_raw_x  <= x;
        i_raw_y  <= y;
        i_raw_z  <= z;
        do @(posedge i_clk); while (full);
        sb.note_item(op, x, y, z);
    endtask

    // leaves the write enable high so writes can go back to back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.note_config(idx, data);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic configure(logic [RANGE_W-1:0] rng, logic [CFG_W-1:0] tgt,
                             logic [CFG_W-1:0] lim);
        settle();
        write_reg(CFG_GYRO_RANGE, CFG_W'(rng));
        write_reg(CFG_CAL_SAMPLES, tgt);
        write_reg(CFG_STILL_LIMIT, lim);
    endtask

    // mostly still samples sized to the current limit, some near it, some anything, a few restarts
    task automatic send_mixed();
        int amp;
        int pick;
        amp  = int'((longint'(sb.limit) * 128) / sb.gain());
        pick = $urandom_range(99);
        if (pick < 3)
            send_item(OP_RESTART, RAW_W'($urandom()), RAW_W'($urandom()),
                      RAW_W'($urandom()));
        else if (pick < 70)
            send_item(OP_SAMPLE, RAW_W'(spread(amp)), RAW_W'(spread(amp)),
                      RAW_W'(spread(amp)));
        else if (pick < 85)
            send_item(OP_SAMPLE, RAW_W'(spread(2 * amp + 1)), RAW_W'(spread(2 * amp + 1)),
                      RAW_W'(spread(2 * amp + 1)));
        else
            send_item(OP_SAMPLE, RAW_W'($urandom()), RAW_W'($urandom()),
                      RAW_W'($urandom()));
    endtask

    initial begin
        int phase;
        int random_sent;
        int n;
        logic [CFG_W-1:0] tgt;
        logic [CFG_W-1:0] lim;

        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults after reset
        send_item(OP_SAMPLE, 0, 0, 0);
        send_item(OP_SAMPLE, 16'sh7FFF, 16'sh8000, -1);
        send_item(OP_SAMPLE, 16'sh8000, 16'sh7FFF, 1);
        send_item(OP_RESTART, 16'sh3039, -1, 16'sh7FFF);
        send_item(OP_SAMPLE, 1, -1, 0);

        // two still samples around a fast one, then the bias is set
        configure(RANGE_DPS2000, 2, 16'hFFFF);
        send_item(OP_SAMPLE, 100, -50, 7);
        send_item(OP_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_SAMPLE, -200, 30, -1);
        send_item(OP_SAMPLE, 5, 5, 5);
        send_item(OP_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000);

        // unused range code, zero target completes at once with zero bias
        configure(RANGE_BAD_HI, 0, 0);
        send_item(OP_RESTART, 0, 0, 0);
        send_item(OP_SAMPLE, 10, 10, 10);

        // limit of one: only a zero rate counts as still
        configure(RANGE_DPS125, 1, 1);
        send_item(OP_SAMPLE, 0, 0, 0);
        send_item(OP_SAMPLE, 16'sh7FFF, 0, 16'sh8000);

        configure(RANGE_DPS250, 3, STILL_LIMIT_RESET);
        write_reg(CFG_GYRO_RANGE, CFG_W'(RANGE_BAD_LO));
        write_reg(CFG_GYRO_RANGE, CFG_W'(RANGE_BAD_HI));
        send_item(OP_RESTART, 0, 0, 0);
        send_item(OP_SAMPLE, 400, -300, 123);
        send_item(OP_SAMPLE, -7, 250, -400);
        send_item(OP_SAMPLE, 33, 0, -1);
        send_item(OP_SAMPLE, 9, 9, 9);
        send_item(OP_SAMPLE, 16'sh7FFF, 16'sh8000, 0);

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            phase++;
            case ($urandom_range(9))
                0:       tgt = 0;
                1:       tgt = 16'hFFFF;
                2:       tgt = CAL_SAMPLES_RESET;
                default: tgt = CFG_W'($urandom_range(1, 24));
            endcase
            case ($urandom_range(7))
                0:       lim = 0;
                1:       lim = 16'hFFFF;
                2:       lim = CFG_W'($urandom_range(1, 200));
                default: lim = CFG_W'($urandom_range(2000, 65535));
            endcase
            configure(RANGE_W'($urandom_range(7)), tgt, lim);
            steady = (phase == 3 || phase == 4);
            n = $urandom_range(40, 110);
            repeat (n) send_mixed();
            random_sent += n;
        end
        steady = 1'b0;

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("gyro_scale_and_bias_calibration regression: pass");
        else
            $display("gyro_scale_and_bias_calibration regression: fail");
        $finish;
    end

endmodule
